/* rtl/core/macd_pkg.sv */
// Shared types and constants for the MACD indicator filter.
package macd_pkg;

  localparam int unsigned ACC_W     = 58;     // tap accumulator, signed
  localparam int unsigned DEN_W     = 24;     // weight sum
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DECAY_W   = 16;
  localparam int unsigned WEIGHT_W  = 17;     // Q1.16
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_DECAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_DECAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_DECAY = 2'd2;

  localparam logic [DECAY_W-1:0] SHORT_DECAY_RST  = 16'd53620;
  localparam logic [DECAY_W-1:0] LONG_DECAY_RST   = 16'd60293;
  localparam logic [DECAY_W-1:0] SIGNAL_DECAY_RST = 16'd49152;

  localparam logic [1:0] ORDER_EQUAL = 2'd0;
  localparam logic [1:0] ORDER_BELOW = 2'd1;
  localparam logic [1:0] ORDER_ABOVE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DSTART,
    ST_DWAIT,
    ST_MWR,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_SHORT,
    PH_LONG,
    PH_SIG
  } phase_e;

  typedef struct packed {
    logic clr;      // restart weight, sums
    logic tap_vld;  // read data is a tap
  } mac_ctrl_t;

endpackage

/* rtl/core/macd_mac.sv */
// Weighted tap accumulator: running weight, weight sum and tap*weight sum.
module macd_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  macd_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [macd_pkg::DATA_W:0]     tap_i,
  input  logic [macd_pkg::DECAY_W-1:0]         decay_i,
  output logic signed [macd_pkg::ACC_W-1:0]    num_o,
  output logic [macd_pkg::DEN_W-1:0]           den_o
);
  import macd_pkg::*;

  localparam int unsigned PROD_W = DATA_W + 1 + WEIGHT_W + 1;

  logic [WEIGHT_W-1:0]            w_q, w_d;
  logic [DEN_W-1:0]               den_q, den_d;
  logic signed [ACC_W-1:0]        num_q, num_d;
  logic signed [PROD_W-1:0]       prod_q, prod_d;
  logic                           pvld_q;
  logic [WEIGHT_W+DECAY_W:0]      wmul;

  assign wmul   = ({1'b0, w_q} * {{(WEIGHT_W+1){1'b0}}, decay_i})
                  + (WEIGHT_W+DECAY_W+1)'(32768);
  assign prod_d = tap_i * $signed({1'b0, w_q});

  always_comb begin
    w_d   = w_q;
    den_d = den_q;
    num_d = num_q;
    if (ctrl_i.clr) begin
      w_d   = WEIGHT_ONE;
      den_d = '0;
      num_d = '0;
    end else begin
      if (ctrl_i.tap_vld) begin
        w_d   = wmul[DECAY_W +: WEIGHT_W];
        den_d = den_q + DEN_W'(w_q);
      end
      if (pvld_q) begin
        num_d = num_q + ACC_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
    end else begin
      pvld_q <= ctrl_i.tap_vld & ~ctrl_i.clr;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    den_q  <= den_d;
    num_q  <= num_d;
    prod_q <= prod_d;
  end

  assign num_o = num_q;
  assign den_o = den_q;

endmodule

/* rtl/core/macd_div.sv */
// Radix-2 restoring divider with round-half-away rounding, 32 quotient bits.
module macd_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [macd_pkg::ACC_W-1:0]  num_i,
  input  logic [macd_pkg::DEN_W-1:0]         den_i,
  output logic                               done_o,
  output logic [macd_pkg::DATA_W-1:0]        quot_o,
  output logic                               neg_o
);
  import macd_pkg::*;

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic [ACC_W-1:0]   mag;
  logic [ACC_W-1:0]   dvd;
  logic [DEN_W-1:0]   rem_q, rem_d;
  logic [DATA_W-1:0]  lo_q, lo_d;
  logic [DEN_W-1:0]   den_q;
  logic               neg_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [DEN_W:0]     trial;
  logic [DEN_W:0]     diff;
  logic               ge;

  assign mag   = num_i[ACC_W-1] ? ACC_W'(-num_i) : ACC_W'(num_i);
  assign dvd   = mag + ACC_W'(den_i >> 1);
  assign trial = {rem_q, lo_q[DATA_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // quotient fits 32 bits, so the high part is already below den
      rem_d  = dvd[DATA_W +: DEN_W];
      lo_d   = dvd[DATA_W-1:0];
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      lo_d  = {lo_q[DATA_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    if (start_i) begin
      den_q <= den_i;
      neg_q <= num_i[ACC_W-1];
    end
  end

  assign done_o = done_q;
  assign quot_o = lo_q;
  assign neg_o  = neg_q;

endmodule

/* rtl/core/macd_indicator_filter_core.sv */
// MACD indicator filter top level: windows in memory, sequencer, output register.
// Per item: warmup items go straight to the output register; once MACD runs, the short
//   and long EMA each take a tap pass over the price window, a drain, a divider start and
//   a divide, then the MACD value is written; once the signal line runs, a signal pass follows.
// One item at a time: a price is taken only in ST_IDLE, once the last result is handed off.
// Reset (rst_ni low, async): control, counts, order history and decay registers
//   cleared to their defaults; window memories are not cleared (a series refills them).
module macd_indicator_filter_core #(
  parameter int unsigned SHORT_PERIOD = 12,
  parameter int unsigned LONG_PERIOD  = 26,
  parameter int unsigned SIGNAL_TAPS  = 9,
  parameter int unsigned CHECK_DEPTH  = 4,
  parameter int unsigned PRICE_WIDTH  = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [macd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [macd_pkg::DECAY_W-1:0]      cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [31:0]                       s_axis_tdata,  // [31:0] price
  input  logic                              s_axis_tuser,  // [0] first
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [71:0]                       m_axis_tdata   // [31:0] macd_value,
                                                           // [63:32] signal_value,
                                                           // [64] macd_valid,
                                                           // [65] signal_valid,
                                                           // [67:66] crossing, rest 0
);
  import macd_pkg::*;

  localparam int unsigned PRICE_DEPTH  = LONG_PERIOD + 1;
  localparam int unsigned MACD_DEPTH   = SIGNAL_TAPS + 1;
  localparam int unsigned SHORT_TAPS   = (SHORT_PERIOD + 1 < PRICE_DEPTH) ?
                                         SHORT_PERIOD + 1 : PRICE_DEPTH;
  localparam int unsigned MACD_START   = LONG_PERIOD + 1;
  localparam int unsigned SIGNAL_START = LONG_PERIOD + SIGNAL_TAPS + 1;
  localparam int unsigned PA_W  = $clog2(PRICE_DEPTH);
  localparam int unsigned MA_W  = $clog2(MACD_DEPTH);
  localparam int unsigned RP_W  = (PA_W > MA_W) ? PA_W : MA_W;
  localparam int unsigned TC_W  = $clog2(PRICE_DEPTH + MACD_DEPTH);
  localparam int unsigned CNT_W = $clog2(SIGNAL_START + 1);
  localparam int unsigned PW    = (PRICE_WIDTH < 32) ? PRICE_WIDTH : 32;
  localparam logic [DATA_W-1:0] PRICE_MASK = 32'hFFFF_FFFF >> (32 - PW);

  // window memories
  logic [DATA_W-1:0] price_mem [PRICE_DEPTH];
  logic [DATA_W-1:0] macd_mem  [MACD_DEPTH];

  logic [DECAY_W-1:0] short_decay_q, long_decay_q, signal_decay_q;

  state_e             state_q, state_d;
  phase_e             phase_q, phase_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [PA_W-1:0]    wp_q, wp_d;
  logic [MA_W-1:0]    mp_q, mp_d;
  logic [RP_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [TC_W-1:0]    tap_q, tap_d;
  logic               drain_q, drain_d;
  logic               mv_q, mv_d, sv_q, sv_d;
  logic [DATA_W-1:0]  ema_s_q, ema_s_d;
  logic signed [DATA_W-1:0] macd_q, macd_d, sig_q, sig_d;
  logic [1:0]         hist_q [CHECK_DEPTH];
  logic [1:0]         hist_d [CHECK_DEPTH];
  logic               out_valid_q, out_valid_d;
  logic [71:0]        out_data_q, out_data_d;

  logic               p_we, m_we, rd_en, rvalid_q;
  logic [DATA_W-1:0]  p_rdata_q, m_rdata_q;
  logic [PA_W-1:0]    wp_next;
  logic [MA_W-1:0]    mp_next;
  logic [CNT_W-1:0]   cnt_new;
  logic [TC_W-1:0]    tap_last;
  logic [RP_W-1:0]    rd_wrap;

  mac_ctrl_t                 mac_ctrl;
  logic signed [DATA_W:0]    mac_tap;
  logic [DECAY_W-1:0]        mac_decay;
  logic signed [ACC_W-1:0]   mac_num;
  logic [DEN_W-1:0]          mac_den;

  logic                      div_start, div_done, div_neg;
  logic [DATA_W-1:0]         div_quot;
  logic signed [DATA_W+1:0]  diff;
  logic [1:0]                order, cross_code;
  logic                      seen;

  // ---------------------------------------------------------------------------
  // Decay registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_decay_q  <= SHORT_DECAY_RST;
      long_decay_q   <= LONG_DECAY_RST;
      signal_decay_q <= SIGNAL_DECAY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SHORT_DECAY:  short_decay_q  <= cfg_data_i;
        REG_LONG_DECAY:   long_decay_q   <= cfg_data_i;
        REG_SIGNAL_DECAY: signal_decay_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Shared datapath
  assign mac_ctrl.clr     = (state_q == ST_RUN) && (tap_q == '0);
  assign mac_ctrl.tap_vld = rvalid_q;
  assign mac_tap = (phase_q == PH_SIG) ? {m_rdata_q[DATA_W-1], m_rdata_q}
                                       : {1'b0, p_rdata_q};

  always_comb begin
    case (phase_q)
      PH_SHORT: mac_decay = short_decay_q;
      PH_LONG:  mac_decay = long_decay_q;
      PH_SIG:   mac_decay = signal_decay_q;
      default:  mac_decay = short_decay_q;
    endcase
  end

  macd_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .tap_i   (mac_tap),
    .decay_i (mac_decay),
    .num_o   (mac_num),
    .den_o   (mac_den)
  );

  macd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mac_num),
    .den_i   (mac_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .neg_o   (div_neg)
  );

  // ---------------------------------------------------------------------------
  // Memories: circular windows, newest entry at the write pointer
  always_ff @(posedge clk_i) begin
    if (p_we) begin
      price_mem[wp_next] <= s_axis_tdata & PRICE_MASK;
    end
    if (m_we) begin
      macd_mem[mp_next] <= macd_q;
    end
    if (rd_en && phase_q != PH_SIG) begin
      p_rdata_q <= price_mem[rd_ptr_q[PA_W-1:0]];
    end
    if (rd_en && phase_q == PH_SIG) begin
      m_rdata_q <= macd_mem[rd_ptr_q[MA_W-1:0]];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  assign wp_next = (wp_q == PA_W'(PRICE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign mp_next = (mp_q == MA_W'(MACD_DEPTH - 1)) ? '0 : mp_q + 1'b1;
  assign cnt_new = s_axis_tuser ? CNT_W'(1) :
                   (cnt_q < CNT_W'(SIGNAL_START)) ? cnt_q + 1'b1 : cnt_q;
  assign diff    = $signed({2'b00, ema_s_q}) - $signed({2'b00, div_quot});

  always_comb begin
    case (phase_q)
      PH_SHORT: tap_last = TC_W'(SHORT_TAPS - 1);
      PH_LONG:  tap_last = TC_W'(PRICE_DEPTH - 1);
      PH_SIG:   tap_last = TC_W'(MACD_DEPTH - 1);
      default:  tap_last = TC_W'(PRICE_DEPTH - 1);
    endcase
    rd_wrap = (phase_q == PH_SIG) ? RP_W'(MACD_DEPTH - 1) : RP_W'(PRICE_DEPTH - 1);
  end

  // order of MACD against signal, and reversal against the history
  always_comb begin
    if (macd_q < sig_q) begin
      order = ORDER_BELOW;
    end else if (macd_q > sig_q) begin
      order = ORDER_ABOVE;
    end else begin
      order = ORDER_EQUAL;
    end
    seen = 1'b0;
    for (int i = 0; i < CHECK_DEPTH; i++) begin
      if (hist_q[i] == order) seen = 1'b1;
    end
    cross_code = (sv_q && order != ORDER_EQUAL && !seen) ? order : ORDER_EQUAL;
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    wp_d        = wp_q;
    mp_d        = mp_q;
    rd_ptr_d    = rd_ptr_q;
    tap_d       = tap_q;
    drain_d     = drain_q;
    mv_d        = mv_q;
    sv_d        = sv_q;
    ema_s_d     = ema_s_q;
    macd_d      = macd_q;
    sig_d       = sig_q;
    hist_d      = hist_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_data_d  = out_data_q;
    p_we        = 1'b0;
    m_we        = 1'b0;
    rd_en       = 1'b0;
    div_start   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          p_we  = 1'b1;
          wp_d  = wp_next;
          cnt_d = cnt_new;
          mv_d  = cnt_new >= CNT_W'(MACD_START);
          sv_d  = cnt_new >= CNT_W'(SIGNAL_START);
          if (s_axis_tuser) begin
            for (int i = 0; i < CHECK_DEPTH; i++) hist_d[i] = ORDER_EQUAL;
          end
          if (cnt_new >= CNT_W'(MACD_START)) begin
            phase_d  = PH_SHORT;
            rd_ptr_d = RP_W'(wp_next);
            tap_d    = '0;
            state_d  = ST_RUN;
          end else begin
            macd_d  = '0;
            sig_d   = '0;
            state_d = ST_DONE;
          end
        end
      end
      ST_RUN: begin
        rd_en    = 1'b1;
        rd_ptr_d = (rd_ptr_q == '0) ? rd_wrap : rd_ptr_q - 1'b1;
        tap_d    = tap_q + 1'b1;
        if (tap_q == tap_last) begin
          drain_d = 1'b0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // product and accumulate stages settle
        drain_d = 1'b1;
        if (drain_q) state_d = ST_DSTART;
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_d   = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          case (phase_q)
            PH_SHORT: begin
              ema_s_d  = div_quot;
              phase_d  = PH_LONG;
              rd_ptr_d = RP_W'(wp_q);
              tap_d    = '0;
              state_d  = ST_RUN;
            end
            PH_LONG: begin
              if (diff > $signed({2'b00, 32'h7FFF_FFFF})) begin
                macd_d = 32'sh7FFF_FFFF;
              end else if (diff < $signed({2'b11, 32'h8000_0000})) begin
                macd_d = 32'sh8000_0000;
              end else begin
                macd_d = diff[DATA_W-1:0];
              end
              state_d = ST_MWR;
            end
            PH_SIG: begin
              sig_d   = div_neg ? -div_quot : div_quot;
              state_d = ST_DONE;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_MWR: begin
        m_we = 1'b1;
        mp_d = mp_next;
        if (sv_q) begin
          phase_d  = PH_SIG;
          rd_ptr_d = RP_W'(mp_next);
          tap_d    = '0;
          state_d  = ST_RUN;
        end else begin
          sig_d   = '0;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {4'b0, cross_code, sv_q, mv_q, sig_q, macd_q};
          for (int i = CHECK_DEPTH - 1; i > 0; i--) hist_d[i] = hist_q[i-1];
          hist_d[0] = order;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_SHORT;
      cnt_q       <= '0;
      wp_q        <= '0;
      mp_q        <= '0;
      tap_q       <= '0;
      drain_q     <= 1'b0;
      mv_q        <= 1'b0;
      sv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      rvalid_q    <= 1'b0;
      for (int i = 0; i < CHECK_DEPTH; i++) hist_q[i] <= ORDER_EQUAL;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      wp_q        <= wp_d;
      mp_q        <= mp_d;
      tap_q       <= tap_d;
      drain_q     <= drain_d;
      mv_q        <= mv_d;
      sv_q        <= sv_d;
      out_valid_q <= out_valid_d;
      rvalid_q    <= rd_en;
      hist_q      <= hist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q   <= rd_ptr_d;
    ema_s_q    <= ema_s_d;
    macd_q     <= macd_d;
    sig_q      <= sig_d;
    out_data_q <= out_data_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(SIGNAL_START))
    else $error("sample count past saturation");

  a_cross_sv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[67:66] != ORDER_EQUAL |-> m_axis_tdata[65])
    else $error("crossing reported without signal line");

  a_warm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[64] |-> m_axis_tdata[63:0] == '0)
    else $error("nonzero result during warmup");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DWAIT)
    else $error("divider finished outside wait state");

endmodule
